// ----- src/dnw_pkg.sv -----
package dnw_pkg;

   localparam int MAX_LABEL = 32;
   localparam int IDX_W     = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
   localparam int FILL_W    = $clog2(MAX_LABEL + 1);
   localparam int COUNT_W   = 10;

   localparam logic [7:0]         CH_DOT    = 8'd46;
   localparam logic [7:0]         CH_NUL    = 8'd0;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [7:0]       data;
   } label_wr_type;

endpackage

// ----- src/dnw_label_buf.sv -----
module dnw_label_buf (
   input  logic                     clock,
   input  dnw_pkg::label_wr_type    wr,
   input  logic [dnw_pkg::IDX_W-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] store_ff [dnw_pkg::MAX_LABEL];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.idx] <= wr.data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/dotted_name_to_dns_wire.sv -----
// Dotted name to DNS wire format. One character is taken per item; label
// characters are written into the label store without holding the input off.
// A dot, a NUL or an end-of-name character holds the input off while the
// result bytes leave one per cycle, while rsp_stall is low, through the output
// register: the length byte, then the buffered label bytes read from a 32-byte
// label store, then two zero bytes at the end of the name. A NUL with no label
// pending sends only the two zero bytes. All of this stretches while rsp_stall
// is high. Characters past 32 in a label are dropped and flagged on
// rsp_overflow until the name ends.
module dotted_name_to_dns_wire (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_ch,
   input  logic                        req_end_of_name,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_is_last,
   output logic                        rsp_overflow,
   output logic [dnw_pkg::COUNT_W-1:0] rsp_byte_count
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN,
      ST_DATA,
      ST_ZERO,
      ST_LAST
   } state_type;

   state_type                     state_ff, state_in;
   logic [dnw_pkg::FILL_W-1:0]    fill_ff, fill_in;
   logic [dnw_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [dnw_pkg::COUNT_W-1:0]   count_ff, count_in, count_inc;
   logic                          ovf_ff, ovf_in;
   logic                          skip_ff, skip_in;
   logic                          finish_ff, finish_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    rsp_byte_ff, rsp_byte_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;
   logic [dnw_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   dnw_pkg::label_wr_type         wr;
   logic [dnw_pkg::IDX_W-1:0]     rd_addr;
   logic [7:0]                    rd_data;
   logic                          emit_ok;
   logic                          label_last;
   logic [dnw_pkg::FILL_W-1:0]    fill_next;

   dnw_label_buf u_label_buf (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign emit_ok    = !rsp_valid_ff || !rsp_stall;
   assign count_inc  = (count_ff == dnw_pkg::COUNT_MAX) ? count_ff
                                                        : count_ff + 1'b1;
   assign label_last = (dnw_pkg::FILL_W'(idx_ff) + dnw_pkg::FILL_W'(1)) == fill_ff;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      skip_in      = skip_ff;
      finish_in    = finish_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_count_in = rsp_count_ff;
      wr.en        = 1'b0;
      wr.idx       = fill_ff[dnw_pkg::IDX_W-1:0];
      wr.data      = req_ch;
      fill_next    = fill_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (state_ff != ST_IDLE && emit_ok) begin
         rsp_valid_in = 1'b1;
         rsp_ovf_in   = ovf_ff;
         rsp_count_in = count_inc;
         rsp_last_in  = 1'b0;
         count_in     = count_inc;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in = '0;
               if (skip_ff) begin
                  skip_in = !req_end_of_name;
               end else if (req_ch == dnw_pkg::CH_NUL) begin
                  finish_in = 1'b1;
                  skip_in   = !req_end_of_name;
                  state_in  = (fill_ff != '0) ? ST_LEN : ST_ZERO;
               end else if (req_ch == dnw_pkg::CH_DOT) begin
                  finish_in = req_end_of_name;
                  state_in  = ST_LEN;
               end else begin
                  if (fill_ff < dnw_pkg::FILL_W'(dnw_pkg::MAX_LABEL)) begin
                     wr.en     = 1'b1;
                     fill_next = fill_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  fill_in   = fill_next;
                  finish_in = req_end_of_name;
                  // label is never empty here, so the end of name flushes it
                  state_in  = req_end_of_name ? ST_LEN : ST_IDLE;
               end
            end
         end
         ST_LEN: begin
            if (emit_ok) begin
               rsp_byte_in = 8'(fill_ff);
               idx_in      = '0;
               if (fill_ff != '0) begin
                  state_in = ST_DATA;
               end else begin
                  state_in = finish_ff ? ST_ZERO : ST_IDLE;
               end
            end
         end
         ST_DATA: begin
            if (emit_ok) begin
               rsp_byte_in = rd_data;
               if (label_last) begin
                  fill_in  = '0;
                  state_in = finish_ff ? ST_ZERO : ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_ZERO: begin
            if (emit_ok) begin
               rsp_byte_in = 8'd0;
               state_in    = ST_LAST;
            end
         end
         ST_LAST: begin
            if (emit_ok) begin
               rsp_byte_in = 8'd0;
               rsp_last_in = 1'b1;
               count_in    = '0;
               fill_in     = '0;
               ovf_in      = 1'b0;
               finish_in   = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // store read is addressed with the next index, so the registered data matches idx_ff
      rd_addr = idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         skip_ff      <= 1'b0;
         finish_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         skip_ff      <= skip_in;
         finish_ff    <= finish_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_is_last    = rsp_last_ff;
   assign rsp_overflow   = rsp_ovf_ff;
   assign rsp_byte_count = rsp_count_ff;

endmodule
